// ===== rtl/core/cfp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the checksummed frame parser: byte constants, status codes,
// parse phase encoding and default sizing. No dependencies.
package cfp_pkg;

    // Frame head byte; also the seed of the running checksum
    localparam logic [7:0] HEAD_BYTE = 8'hFF;

    // Default largest payload, in bytes
    localparam int MAX_PAYLOAD_DEF = 4;

    // Result field widths
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 3;
    localparam int PAYLOAD_W = 32;
    localparam int PACK_BYTES = PAYLOAD_W / 8;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD   = 2'd0,
        ST_BADSUM = 2'd1,
        ST_BADLEN = 2'd2
    } t_status;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_ADDR   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

endpackage

// ===== rtl/core/cfp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces of the frame parser: byte input and result.
// Depends on cfp_pkg.
interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
    import cfp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [7:0]           reg_addr;
    logic [COUNT_W-1:0]   payload_count;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output status, output reg_addr,
                    output payload_count, output payload, input ready);
    modport sink   (input valid, input status, input reg_addr,
                    input payload_count, input payload, output ready);
endinterface

// ===== rtl/core/checksummed_frame_parser_top.sv =====
`timescale 1ns / 1ps
// Checksummed serial frame parser, top level.
// Depends on cfp_pkg and the stream interfaces in cfp_if.
//
// Usage:
//   i_rx  : one received byte per request (valid/ready). Frames are
//           FF, length L, address (if L > 0), L-1 payload bytes, checksum.
//           The checksum is the 8-bit sum of head, length, address and payload.
//   o_res : one result request per frame end: status (good, checksum mismatch,
//           length too large), address, payload byte count and payload packed
//           first byte in bits 31:24. Bytes that complete nothing give no result.
//   Throughput: one byte per cycle, one parse step per byte, unless o_res stalls.
//   Path: a taken byte lands in the input register; its result, if any, is
//           written to the output register when the parse step advances.
//   A byte may be taken while a finished result still waits in the output
//   register; the input register only holds when that result is not taken.
//   Stall: o_res.valid and the fields hold until o_res.ready; back-pressure
//   reaches i_rx.ready combinationally through one register stage.
//   Reset (i_rst_n low, synchronous): back to hunting for a head byte, both
//   register stages empty.
module checksummed_frame_parser_top #(
    parameter int MAX_PAYLOAD = cfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfp_byte_if.sink      i_rx,
    cfp_result_if.source  o_res
);
    import cfp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PACK_N = (MAX_PAYLOAD < PACK_BYTES) ? MAX_PAYLOAD : PACK_BYTES;
    localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD + 1);

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Parser state
    t_phase           r_phase,  n_phase;
    logic [7:0]       r_sum,    n_sum;
    logic [CNT_W-1:0] r_exp,    n_exp;
    logic [CNT_W-1:0] r_rcv,    n_rcv;
    logic [7:0]       r_addr,   n_addr;
    logic [7:0]       r_store [MAX_PAYLOAD];
    logic [7:0]       n_store [MAX_PAYLOAD];

    // Output register
    logic                 r_out_vld;
    t_status              r_out_status,  n_out_status;
    logic [7:0]           r_out_addr,    n_out_addr;
    logic [COUNT_W-1:0]   r_out_count,   n_out_count;
    logic [PAYLOAD_W-1:0] r_out_payload, n_out_payload;

    logic                 advance;
    logic                 emit;
    logic [CNT_W-1:0]     rcv_inc;
    logic [CNT_W+COUNT_W-1:0] rcv_wide;
    logic [PAYLOAD_W-1:0] packed_store;

    // Handshake: the parse step moves when the output slot is free or drains
    assign advance    = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || advance;

    assign rcv_inc  = r_rcv + CNT_W'(1);
    assign rcv_wide = {{COUNT_W{1'b0}}, r_rcv};

    // Pack the first stored payload bytes, first byte at the top
    always_comb begin
        packed_store = '0;
        for (int i = 0; i < PACK_N; i++) begin
            packed_store[PAYLOAD_W-1-8*i -: 8] = r_store[i];
        end
    end

    // One parse step per byte
    always_comb begin
        n_phase       = r_phase;
        n_sum         = r_sum;
        n_exp         = r_exp;
        n_rcv         = r_rcv;
        n_addr        = r_addr;
        n_store       = r_store;
        emit          = 1'b0;
        n_out_status  = ST_GOOD;
        n_out_addr    = r_addr;
        n_out_count   = rcv_wide[COUNT_W-1:0];
        n_out_payload = packed_store;

        // checksum accumulates every frame byte but the checksum itself
        if (r_phase != PH_HUNT && r_phase != PH_CHECK) begin
            n_sum = r_sum + r_in_byte;
        end

        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == HEAD_BYTE) begin
                    n_sum   = HEAD_BYTE;
                    n_exp   = '0;
                    n_rcv   = '0;
                    n_addr  = '0;
                    for (int i = 0; i < MAX_PAYLOAD; i++) begin
                        n_store[i] = '0;
                    end
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (r_in_byte == 8'd0) begin
                    n_exp   = '0;
                    n_phase = PH_CHECK;
                end else if ({1'b0, r_in_byte} > LEN_LIMIT) begin
                    // oversize length: report at once
                    n_phase       = PH_HUNT;
                    emit          = 1'b1;
                    n_out_status  = ST_BADLEN;
                    n_out_addr    = '0;
                    n_out_count   = '0;
                    n_out_payload = '0;
                end else begin
                    n_exp   = CNT_W'(r_in_byte - 8'd1);
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                n_addr  = r_in_byte;
                n_phase = (r_exp == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                n_store[r_rcv[IDX_W-1:0]] = r_in_byte;
                n_rcv = rcv_inc;
                if (rcv_inc >= r_exp) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase      = PH_HUNT;
                emit         = 1'b1;
                n_out_status = (r_sum == r_in_byte) ? ST_GOOD : ST_BADSUM;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_HUNT;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance && emit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (advance) begin
                r_phase <= n_phase;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= HEAD_BYTE;
            r_exp  <= '0;
            r_rcv  <= '0;
            r_addr <= '0;
            for (int i = 0; i < MAX_PAYLOAD; i++) begin
                r_store[i] <= '0;
            end
        end else if (advance) begin
            r_sum   <= n_sum;
            r_exp   <= n_exp;
            r_rcv   <= n_rcv;
            r_addr  <= n_addr;
            r_store <= n_store;
        end
    end

    // Input byte and result fields, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance && emit) begin
            r_out_status  <= n_out_status;
            r_out_addr    <= n_out_addr;
            r_out_count   <= n_out_count;
            r_out_payload <= n_out_payload;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out_status;
    assign o_res.reg_addr      = r_out_addr;
    assign o_res.payload_count = r_out_count;
    assign o_res.payload       = r_out_payload;

endmodule

// ===== rtl/core/cfp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the frame parser and its bind to the top level.
// Depends on cfp_pkg and checksummed_frame_parser_top.
module cfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_reg_addr,
    input logic [2:0]  i_payload_count,
    input logic [31:0] i_payload
);
    import cfp_pkg::*;

    // A stalled result request stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result request dropped while stalled");

    // Reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Length errors carry no frame contents
    a_badlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_status == ST_BADLEN |->
            i_reg_addr == 8'd0 && i_payload_count == 3'd0 && i_payload == 32'd0)
        else $error("length error with frame contents");

    // Bytes past the payload count are zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_payload_count == 3'd0 |-> i_payload == 32'd0)
        else $error("payload set with no payload bytes");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_payload_count == 3'd1 |-> i_payload[23:0] == 24'd0)
        else $error("payload bytes past a single-byte count");

endmodule

bind checksummed_frame_parser_top cfp_checker u_cfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_reg_addr      (o_res.reg_addr),
    .i_payload_count (o_res.payload_count),
    .i_payload       (o_res.payload)
);
